[rtl/core/clr_pkg.sv]
// ----------------------------------------------------------------------------
// clr_pkg
// Shared types and constants of the clipped line rasterizer.
// ----------------------------------------------------------------------------
package clr_pkg;

  localparam int unsigned ScreenWidth  = 4096;
  localparam int unsigned ScreenHeight = 4096;
  localparam int unsigned ClipSteps    = 8;
  localparam int unsigned CW           = 16;   // clip coordinate width
  localparam int unsigned PW           = 30;   // product width
  localparam int unsigned QW           = 17;   // quotient width

  localparam logic [1:0] ST_NONE   = 2'd0;
  localparam logic [1:0] ST_PIXEL  = 2'd1;
  localparam logic [1:0] ST_ACCEPT = 2'd2;
  localparam logic [1:0] ST_REJECT = 2'd3;

  localparam logic [1:0] REG_MIN_X = 2'd0;
  localparam logic [1:0] REG_MAX_X = 2'd1;
  localparam logic [1:0] REG_MIN_Y = 2'd2;
  localparam logic [1:0] REG_MAX_Y = 2'd3;

  localparam logic [3:0] OC_TOP    = 4'd8;
  localparam logic [3:0] OC_BOTTOM = 4'd4;
  localparam logic [3:0] OC_RIGHT  = 4'd2;
  localparam logic [3:0] OC_LEFT   = 4'd1;

  typedef struct packed {
    logic load;     // latch endpoints, color, outcodes
    logic prep;     // compute numerator and denominator
    logic mul;      // register product
    logic div_go;   // start divider
    logic apply;    // write back clipped endpoint
    logic setup;    // build Bresenham state
    logic tick;     // advance one pixel
  } dp_cmd_t;

  typedef struct packed {
    logic [3:0] c1;
    logic [3:0] c2;
    logic       div_busy;
    logic       active;
    logic       at_final;
  } dp_sts_t;

  function automatic logic [3:0] outcode(input logic signed [CW-1:0] x,
                                         input logic signed [CW-1:0] y,
                                         input logic signed [CW-1:0] xl,
                                         input logic signed [CW-1:0] xh,
                                         input logic signed [CW-1:0] yl,
                                         input logic signed [CW-1:0] yh);
    logic [3:0] c;
    c = 4'd0;
    if (y > yh) c = c | OC_TOP;
    else if (y < yl) c = c | OC_BOTTOM;
    if (x > xh) c = c | OC_RIGHT;
    else if (x < xl) c = c | OC_LEFT;
    return c;
  endfunction

endpackage

[rtl/core/clr_div.sv]
// ----------------------------------------------------------------------------
// clr_div
// Restoring signed divider, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
module clr_div
  import clr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [PW-1:0] num,
  input  logic signed [CW-1:0] den,
  output logic                 busy,
  output logic signed [QW-1:0] quo
);

  localparam int unsigned CntW = $clog2(PW + 1);

  logic [PW-1:0]   rem_r, rem_nxt;
  logic [PW-1:0]   q_r, q_nxt;
  logic [CW-1:0]   d_r, d_nxt;
  logic            neg_r, neg_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt;
  logic [PW:0]     trial;
  logic [PW-1:0]   shifted;
  logic [PW-1:0]   qneg;

  always_comb begin
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    d_nxt    = d_r;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    shifted  = {rem_r[PW-2:0], q_r[PW-1]};
    trial    = {1'b0, shifted} - {{(PW+1-CW){1'b0}}, d_r};
    if (start) begin
      rem_nxt  = '0;
      q_nxt    = num[PW-1] ? PW'(-num) : PW'(num);
      d_nxt    = den[CW-1] ? CW'(-den) : CW'(den);
      neg_nxt  = num[PW-1] ^ den[CW-1];
      cnt_nxt  = CntW'(PW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[PW]) begin
        rem_nxt = trial[PW-1:0];
        q_nxt   = {q_r[PW-2:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        q_nxt   = {q_r[PW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntW'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    d_r   <= d_nxt;
    neg_r <= neg_nxt;
  end

  assign qneg = neg_r ? PW'(-q_r) : q_r;
  assign quo  = QW'(qneg);
  assign busy = busy_r;

endmodule

[rtl/core/clr_datapath.sv]
// ----------------------------------------------------------------------------
// clr_datapath
// Endpoint registers, clip arithmetic, Bresenham stepping and window config.
// ----------------------------------------------------------------------------
module clr_datapath
  import clr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  dp_cmd_t            cmd,
  output dp_sts_t            sts,
  input  logic signed [13:0] in_x1,
  input  logic signed [13:0] in_y1,
  input  logic signed [13:0] in_x2,
  input  logic signed [13:0] in_y2,
  input  logic [23:0]        in_color,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_idx,
  input  logic [11:0]        cfg_val,
  output logic [11:0]        cfg_rd [4],
  output logic [11:0]        px_x,
  output logic [11:0]        px_y,
  output logic [23:0]        px_color
);

  logic [11:0] min_x_r, max_x_r, min_y_r, max_y_r;
  logic signed [CW-1:0] x1_r, y1_r, x2_r, y2_r;
  logic [3:0]  c1_r, c2_r;
  logic [23:0] color_r, line_color_r;
  logic signed [CW-1:0] base_r, dlt_r, den_r, bound_r;
  logic signed [PW-1:0] prod_r;
  logic        sel_y_r;       // clipping against a y edge
  logic        on_p1_r;
  logic [11:0] cur_x_r, cur_y_r, fin_r;
  logic signed [15:0] err_r;
  logic [12:0] dmaj_r, dmin_r;
  logic        up_r, xmaj_r, act_r;

  logic signed [CW-1:0] xl, xh, yl, yh;
  logic signed [QW-1:0] quo;
  logic        div_busy;
  logic [3:0]  code;
  logic signed [CW-1:0] nx, ny, nv;
  logic signed [CW-1:0] dx, dy, adx, ady;
  logic        xm;
  logic signed [CW-1:0] sx1, sy1, sx2, sy2;
  logic [11:0] maj, mnr, mnr_nx;

  assign xl = CW'(min_x_r);
  assign yl = CW'(min_y_r);
  assign xh = (32'(max_x_r) > ScreenWidth - 1)  ? CW'(ScreenWidth - 1)  : CW'(max_x_r);
  assign yh = (32'(max_y_r) > ScreenHeight - 1) ? CW'(ScreenHeight - 1) : CW'(max_y_r);

  clr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_go),
    .num   (prod_r),
    .den   (den_r),
    .busy  (div_busy),
    .quo   (quo)
  );

  assign code = (c1_r != 4'd0) ? c1_r : c2_r;
  assign nv   = CW'(32'(signed'(base_r)) + 32'(signed'(quo)));
  assign nx   = sel_y_r ? nv : bound_r;
  assign ny   = sel_y_r ? bound_r : nv;

  assign dx  = x2_r - x1_r;
  assign dy  = y2_r - y1_r;
  assign adx = dx[CW-1] ? -dx : dx;
  assign ady = dy[CW-1] ? -dy : dy;
  assign xm  = adx >= ady;
  always_comb begin
    sx1 = x1_r; sy1 = y1_r; sx2 = x2_r; sy2 = y2_r;
    if ((xm && x1_r > x2_r) || (!xm && y1_r > y2_r)) begin
      sx1 = x2_r; sy1 = y2_r; sx2 = x1_r; sy2 = y1_r;
    end
  end

  assign maj    = xmaj_r ? cur_x_r : cur_y_r;
  assign mnr    = xmaj_r ? cur_y_r : cur_x_r;
  assign mnr_nx = up_r ? mnr + 12'd1 : mnr - 12'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_x_r <= 12'd0; max_x_r <= 12'hFFF;
      min_y_r <= 12'd0; max_y_r <= 12'hFFF;
      act_r   <= 1'b0;
      xmaj_r  <= 1'b1;
      cur_x_r <= '0; cur_y_r <= '0; fin_r <= '0; err_r <= '0;
      dmaj_r  <= '0; dmin_r <= '0; up_r <= 1'b0; line_color_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_MIN_X: min_x_r <= cfg_val;
          REG_MAX_X: max_x_r <= cfg_val;
          REG_MIN_Y: min_y_r <= cfg_val;
          REG_MAX_Y: max_y_r <= cfg_val;
          default: ;
        endcase
      end
      if (cmd.load) act_r <= 1'b0;
      if (cmd.setup) begin
        xmaj_r  <= xm;
        fin_r   <= xm ? sx2[11:0] : sy2[11:0];
        up_r    <= xm ? (sy2 > sy1) : (sx2 > sx1);
        dmaj_r  <= xm ? adx[12:0] : ady[12:0];
        dmin_r  <= xm ? ady[12:0] : adx[12:0];
        cur_x_r <= sx1[11:0];
        cur_y_r <= sy1[11:0];
        err_r   <= 16'(2 * 32'(signed'(xm ? ady : adx)) - 32'(signed'(xm ? adx : ady)));
        line_color_r <= color_r;
        act_r   <= 1'b1;
      end
      if (cmd.tick) begin
        if (maj == fin_r) begin
          act_r <= 1'b0;
        end else begin
          if (err_r[15]) begin
            err_r <= err_r + 16'(signed'({3'b0, dmin_r} << 1));
          end else begin
            err_r <= err_r + 16'((signed'({3'b0, dmin_r}) - signed'({3'b0, dmaj_r})) <<< 1);
            if (xmaj_r) cur_y_r <= mnr_nx;
            else cur_x_r <= mnr_nx;
          end
          if (xmaj_r) cur_x_r <= cur_x_r + 12'd1;
          else cur_y_r <= cur_y_r + 12'd1;
        end
      end
    end
    if (cmd.load) begin
      x1_r <= CW'(in_x1); y1_r <= CW'(in_y1);
      x2_r <= CW'(in_x2); y2_r <= CW'(in_y2);
      c1_r <= outcode(CW'(in_x1), CW'(in_y1), xl, xh, yl, yh);
      c2_r <= outcode(CW'(in_x2), CW'(in_y2), xl, xh, yl, yh);
      color_r <= in_color;
    end
    if (cmd.prep) begin
      on_p1_r <= c1_r != 4'd0;
      if ((code & (OC_TOP | OC_BOTTOM)) != 4'd0) begin
        sel_y_r <= 1'b1;
        bound_r <= ((code & OC_TOP) != 4'd0) ? yh : yl;
        base_r  <= x1_r;
        dlt_r   <= x2_r - x1_r;
        den_r   <= y2_r - y1_r;
        prod_r  <= PW'((((code & OC_TOP) != 4'd0) ? yh : yl) - y1_r);
      end else begin
        sel_y_r <= 1'b0;
        bound_r <= ((code & OC_RIGHT) != 4'd0) ? xh : xl;
        base_r  <= y1_r;
        dlt_r   <= y2_r - y1_r;
        den_r   <= x2_r - x1_r;
        prod_r  <= PW'((((code & OC_RIGHT) != 4'd0) ? xh : xl) - x1_r);
      end
    end
    if (cmd.mul) prod_r <= PW'(dlt_r * prod_r);
    if (cmd.apply) begin
      if (on_p1_r) begin
        x1_r <= nx; y1_r <= ny; c1_r <= outcode(nx, ny, xl, xh, yl, yh);
      end else begin
        x2_r <= nx; y2_r <= ny; c2_r <= outcode(nx, ny, xl, xh, yl, yh);
      end
    end
  end

  assign sts.c1       = c1_r;
  assign sts.c2       = c2_r;
  assign sts.div_busy = div_busy;
  assign sts.active   = act_r;
  assign sts.at_final = maj == fin_r;

  assign cfg_rd[0] = min_x_r;
  assign cfg_rd[1] = max_x_r;
  assign cfg_rd[2] = min_y_r;
  assign cfg_rd[3] = max_y_r;

  assign px_x     = cur_x_r;
  assign px_y     = cur_y_r;
  assign px_color = line_color_r;

endmodule

[rtl/core/clr_ctrl.sv]
// ----------------------------------------------------------------------------
// clr_ctrl
// Sequencer: accepts items, runs the clip loop, drives the output register.
// ----------------------------------------------------------------------------
module clr_ctrl
  import clr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic       in_func,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [1:0] out_status,
  output logic       out_last,
  output logic       out_pix,
  output dp_cmd_t    cmd,
  input  dp_sts_t    sts
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_PREP  = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_WAIT  = 3'd5;
  localparam logic [2:0] S_APPLY = 3'd6;

  localparam int unsigned StW = $clog2(ClipSteps + 1);

  logic [2:0]     state_r, state_nxt;
  logic [StW-1:0] step_r, step_nxt;
  logic           ov_r, ov_nxt;
  logic [1:0]     ost_r, ost_nxt;
  logic           olast_r, olast_nxt;
  logic           opix_r, opix_nxt;
  logic           slot_free, acc;

  assign slot_free = !ov_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && slot_free;
  assign acc       = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    ov_nxt    = ov_r && !out_tready;
    ost_nxt   = ost_r;
    olast_nxt = olast_r;
    opix_nxt  = opix_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          if (!in_func) begin
            cmd.load  = 1'b1;
            step_nxt  = '0;
            state_nxt = S_CHECK;
          end else begin
            ov_nxt    = 1'b1;
            opix_nxt  = sts.active;
            ost_nxt   = sts.active ? ST_PIXEL : ST_NONE;
            olast_nxt = sts.active && sts.at_final;
            cmd.tick  = sts.active;
          end
        end
      end
      S_CHECK: begin
        if ((sts.c1 | sts.c2) == 4'd0) begin
          if (slot_free) begin
            cmd.setup = 1'b1;
            ov_nxt = 1'b1; ost_nxt = ST_ACCEPT; olast_nxt = 1'b0; opix_nxt = 1'b0;
            state_nxt = S_IDLE;
          end
        end else if ((sts.c1 & sts.c2) != 4'd0 || step_r == StW'(ClipSteps)) begin
          if (slot_free) begin
            ov_nxt = 1'b1; ost_nxt = ST_REJECT; olast_nxt = 1'b0; opix_nxt = 1'b0;
            state_nxt = S_IDLE;
          end
        end else begin
          state_nxt = S_PREP;
        end
      end
      S_PREP:  begin cmd.prep = 1'b1; state_nxt = S_MUL; end
      S_MUL:   begin cmd.mul = 1'b1; state_nxt = S_DIV; end
      S_DIV:   begin cmd.div_go = 1'b1; state_nxt = S_WAIT; end
      S_WAIT:  if (!sts.div_busy) state_nxt = S_APPLY;
      S_APPLY: begin
        cmd.apply = 1'b1;
        step_nxt  = step_r + 1'b1;
        state_nxt = S_CHECK;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      ov_r    <= ov_nxt;
    end
    ost_r   <= ost_nxt;
    olast_r <= olast_nxt;
    opix_r  <= opix_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_status = ost_r;
  assign out_last   = olast_r;
  assign out_pix    = opix_r;

endmodule

[rtl/core/clipped_line_rasterizer_unit.sv]
// ----------------------------------------------------------------------------
// clipped_line_rasterizer_unit
// Clips line commands to a window and emits Bresenham pixels on ticks.
// ----------------------------------------------------------------------------
// Input stream: tuser = func (0 line load, 1 tick), tdata = endpoints + color.
// Output stream: tuser = status, tlast = last pixel, tdata = x, y, color.
// Config: APB, four 12-bit window registers at 0x0, 0x4, 0x8, 0xC.
// A tick yields one pixel per clock while the output is taken.
// A line load latches the endpoints, then runs up to 8 clip passes; each
// pass runs prep, a registered multiply and a restoring divider. No input
// is taken until the load has finished.
// The result waits in an output register; input is taken while it is
// drained in the same cycle. A stalled receiver stalls the input.
// Synchronous reset restores the full-screen window and drops any line.
// ----------------------------------------------------------------------------
module clipped_line_rasterizer_unit
  import clr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,  // start_x, start_y, end_x, end_y, color
  input  logic        in_tuser,  // func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata, // pixel_x, pixel_y, pixel_color
  output logic [1:0]  out_tuser, // status
  output logic        out_tlast, // last_pixel
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  dp_cmd_t     cmd;
  dp_sts_t     sts;
  logic        opix;
  logic [11:0] px_x, px_y;
  logic [23:0] px_color;
  logic [11:0] cfg_rd [4];
  logic        cfg_we;

  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[1:0] == 2'd0;
  assign cfg_prdata = (cfg_paddr[1:0] == 2'd0) ? {20'd0, cfg_rd[cfg_paddr[3:2]]} : 32'd0;

  clr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_func    (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_status (out_tuser),
    .out_last   (out_tlast),
    .out_pix    (opix),
    .cmd        (cmd),
    .sts        (sts)
  );

  clr_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .in_x1    (in_tdata[13:0]),
    .in_y1    (in_tdata[27:14]),
    .in_x2    (in_tdata[41:28]),
    .in_y2    (in_tdata[55:42]),
    .in_color (in_tdata[79:56]),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_paddr[3:2]),
    .cfg_val  (cfg_pwdata[11:0]),
    .cfg_rd   (cfg_rd),
    .px_x     (px_x),
    .px_y     (px_y),
    .px_color (px_color)
  );

  // Pixel registers only advance on a tick, so they still hold the emitted pixel.
  logic [47:0] pix_r;
  always_ff @(posedge clk) begin
    if (cmd.tick) pix_r <= {px_color, px_y, px_x};
  end
  assign out_tdata = opix ? pix_r : 48'd0;

endmodule

[test/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives line loads and pixel ticks into the clipped line rasterizer under
// changing clip windows. A scoreboard predicts each result from its own
// copy of the clip and Bresenham state and compares every output item.
// ----------------------------------------------------------------------------
module tb
  import clr_pkg::*;
();

  class line_scoreboard;
    longint      win_xl, win_xh, win_yl, win_yh;
    logic [11:0] cur_x, cur_y, end_major;
    int          err_acc, d_major, d_minor;
    bit          step_up, x_major, active;
    logic [23:0] ln_color;
    logic [50:0] pending[$];
    int          errors;

    function void clear();
      win_xl = 0; win_xh = 4095; win_yl = 0; win_yh = 4095;
      cur_x = 0; cur_y = 0; end_major = 0; err_acc = 0;
      d_major = 0; d_minor = 0; step_up = 0; x_major = 1; active = 0;
      ln_color = 0; pending.delete(); errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [11:0] v);
      case (idx)
        REG_MIN_X: win_xl = longint'(v);
        REG_MAX_X: win_xh = longint'(v);
        REG_MIN_Y: win_yl = longint'(v);
        default:   win_yh = longint'(v);
      endcase
    endfunction

    function logic [3:0] region(longint x, longint y);
      logic [3:0] c;
      c = 0;
      if (y > win_yh) c |= OC_TOP; else if (y < win_yl) c |= OC_BOTTOM;
      if (x > win_xh) c |= OC_RIGHT; else if (x < win_xl) c |= OC_LEFT;
      return c;
    endfunction

    function logic [1:0] clip_and_setup(longint x1, longint y1, longint x2,
                                        longint y2, logic [23:0] col);
      logic [3:0] c1, c2, code;
      longint nx, ny, dx, dy, t;
      c1 = region(x1, y1);
      c2 = region(x2, y2);
      active = 0;
      for (int i = 0; i < ClipSteps && (c1 | c2) != 0 && (c1 & c2) == 0; i++) begin
        code = (c1 != 0) ? c1 : c2;
        if (code & OC_TOP) begin
          nx = x1 + (x2 - x1) * (win_yh - y1) / (y2 - y1); ny = win_yh;
        end else if (code & OC_BOTTOM) begin
          nx = x1 + (x2 - x1) * (win_yl - y1) / (y2 - y1); ny = win_yl;
        end else if (code & OC_RIGHT) begin
          ny = y1 + (y2 - y1) * (win_xh - x1) / (x2 - x1); nx = win_xh;
        end else begin
          ny = y1 + (y2 - y1) * (win_xl - x1) / (x2 - x1); nx = win_xl;
        end
        if (c1 != 0) begin
          x1 = nx; y1 = ny; c1 = region(x1, y1);
        end else begin
          x2 = nx; y2 = ny; c2 = region(x2, y2);
        end
      end
      if ((c1 | c2) != 0) return ST_REJECT;
      dx = (x2 > x1) ? x2 - x1 : x1 - x2;
      dy = (y2 > y1) ? y2 - y1 : y1 - y2;
      if (dx >= dy) begin
        if (x1 > x2) begin
          t = x1; x1 = x2; x2 = t; t = y1; y1 = y2; y2 = t;
        end
        x_major = 1; end_major = x2[11:0]; step_up = y2 > y1;
        d_major = int'(dx); d_minor = int'(dy);
      end else begin
        if (y1 > y2) begin
          t = x1; x1 = x2; x2 = t; t = y1; y1 = y2; y2 = t;
        end
        x_major = 0; end_major = y2[11:0]; step_up = x2 > x1;
        d_major = int'(dy); d_minor = int'(dx);
      end
      cur_x = x1[11:0]; cur_y = y1[11:0];
      err_acc = 2 * d_minor - d_major;
      ln_color = col;
      active = 1;
      return ST_ACCEPT;
    endfunction

    // result packed as {last, status, color, y, x}
    function void note_item(bit func, logic [79:0] d);
      logic [1:0]  st;
      logic [11:0] px, py;
      logic [23:0] pc;
      bit          lst;
      logic [11:0] mj;
      st = ST_NONE; px = 0; py = 0; pc = 0; lst = 0;
      if (!func) begin
        st = clip_and_setup(longint'($signed(d[13:0])), longint'($signed(d[27:14])),
                            longint'($signed(d[41:28])), longint'($signed(d[55:42])),
                            d[79:56]);
      end else if (active) begin
        st = ST_PIXEL; px = cur_x; py = cur_y; pc = ln_color;
        mj = x_major ? cur_x : cur_y;
        if (mj == end_major) begin
          lst = 1; active = 0;
        end else begin
          if (err_acc < 0) err_acc += 2 * d_minor;
          else begin
            err_acc += 2 * (d_minor - d_major);
            if (x_major) cur_y = step_up ? cur_y + 12'd1 : cur_y - 12'd1;
            else cur_x = step_up ? cur_x + 12'd1 : cur_x - 12'd1;
          end
          if (x_major) cur_x = cur_x + 12'd1; else cur_y = cur_y + 12'd1;
        end
      end
      pending.insert(pending.size(), {lst, st, pc, py, px});
    endfunction

    function void check_result(logic [1:0] st, logic [47:0] d, logic lst);
      logic [50:0] exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result status=%0d data=%h", $time, st, d);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (st !== exp_r[49:48] || d[11:0] !== exp_r[11:0] || d[23:12] !== exp_r[23:12]
          || d[47:24] !== exp_r[47:24] || lst !== exp_r[50]) begin
        $display("%0t: mismatch expected st=%0d x=%0d y=%0d c=%h last=%0d",
                 $time, exp_r[49:48], exp_r[11:0], exp_r[23:12], exp_r[47:24], exp_r[50]);
        $display("%0t:          actual   st=%0d x=%0d y=%0d c=%h last=%0d",
                 $time, st, d[11:0], d[23:12], d[47:24], lst);
        errors++;
      end
    endfunction
  endclass

  logic        clk, rst_n;
  logic        in_tvalid, in_tready, in_tuser;
  logic [79:0] in_tdata;
  logic        out_tvalid, out_tready, out_tlast;
  logic [47:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;

  line_scoreboard sb;
  int  cycles;
  bit  quiet;
  bit  long_hold;

  clipped_line_rasterizer_unit dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 2000000) begin
        $display("tb: done, errors");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tuser, out_tdata, out_tlast);
  end

  initial begin
    int n;
    out_tready <= 0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_tready <= 0;
        repeat (400) @(posedge clk);
        long_hold = 0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 10);
        out_tready <= 0;
        repeat (n - 1) @(posedge clk);
      end else begin
        out_tready <= 1;
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [11:0] v);
    cfg_psel <= 1; cfg_penable <= 0; cfg_pwrite <= 1;
    cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= {20'd0, v};
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
    sb.set_reg(idx, v);
  endtask

  task automatic send(bit func, logic [79:0] d);
    int n;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 10);
      in_tvalid <= 0;
      repeat (n) @(posedge clk);
    end
    in_tvalid <= 1; in_tuser <= func; in_tdata <= d;
    do @(posedge clk); while (!in_tready);
    sb.note_item(func, d);
  endtask

  task automatic finish_phase();
    in_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  function automatic logic [79:0] line_data(int x1, int y1, int x2, int y2,
                                             logic [23:0] c);
    return {c, 14'(y2), 14'(x2), 14'(y1), 14'(x1)};
  endfunction

  task automatic draw(logic [79:0] d, int ticks);
    send(0, d);
    repeat (ticks) send(1, 80'd0);
  endtask

  function automatic int coord();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 16383) - 8192;
      1: return $urandom_range(0, 4200) - 50;
      default: return $urandom_range(0, 60) + 20;
    endcase
  endfunction

  task automatic random_lines(int count);
    int x1, y1;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        send(1, 80'({$urandom, $urandom, $urandom}));
      end else begin
        x1 = coord(); y1 = coord();
        if ($urandom_range(0, 2) == 0)
          send(0, 80'({$urandom, $urandom, $urandom}));
        else
          draw(line_data(x1, y1, x1 + $urandom_range(0, 40) - 20,
                         y1 + $urandom_range(0, 40) - 20, 24'($urandom)),
               $urandom_range(0, 24));
      end
    end
  endtask

  initial begin
    sb = new();
    sb.clear();
    quiet = 0; long_hold = 0;
    in_tvalid <= 0; in_tuser <= 0; in_tdata <= 0;
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0; cfg_paddr <= 0; cfg_pwdata <= 0;
    rst_n <= 0;
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    send(1, 80'd0);
    draw(line_data(5, 5, 5, 5, 24'hFFFFFF), 2);
    draw(line_data(-8192, -8192, 8191, 8191, 24'h000001), 3);
    draw(line_data(8191, 10, -8192, 20, 24'h800000), 2);
    draw(line_data(4095, 4095, 4090, 4000, 24'h00FF00), 4);
    send(0, line_data(-5, -5, -1, -9, 24'h123456));
    draw(line_data(0, 0, 10, 3, 24'hABCDEF), 1);
    draw(line_data(0, 10, 3, 0, 24'h0F0F0F), 12);
    finish_phase();

    write_reg(REG_MIN_X, 100); write_reg(REG_MAX_X, 200);
    write_reg(REG_MIN_Y, 50);  write_reg(REG_MAX_Y, 150);
    draw(line_data(0, 0, 300, 200, 24'h111111), 5);
    draw(line_data(150, -100, 160, 400, 24'h222222), 3);
    random_lines(10);
    long_hold = 1;
    random_lines(7);
    finish_phase();

    write_reg(REG_MIN_X, 12'hFFF); write_reg(REG_MAX_X, 0);
    draw(line_data(10, 10, 20, 20, 24'h333333), 2);
    random_lines(5);
    finish_phase();

    write_reg(REG_MIN_X, 60); write_reg(REG_MAX_X, 70);
    write_reg(REG_MIN_Y, 0);  write_reg(REG_MAX_Y, 12'hFFF);
    random_lines(10);
    finish_phase();

    write_reg(REG_MIN_X, 0); write_reg(REG_MAX_X, 12'hFFF);
    write_reg(REG_MIN_Y, 30); write_reg(REG_MAX_Y, 90);
    random_lines(8);
    quiet = 1;
    random_lines(4);
    finish_phase();

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end
endmodule
